// File: hdl/dphd_pkg.sv
// Package for the drum pad hit detector.
// Types, register indexes and mode codes shared by all design files.
// No dependencies.
package dphd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 8;
  localparam int ENERGY_W    = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE       = 3'd4;

  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_VALIDATING = 2'd1;
  localparam logic [1:0] MODE_LOCKED     = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_in_block;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_peak;
    logic                candidate_started;
    logic                validation_completed;
    logic                hit_detected;
    logic [SAMPLE_W-1:0] validation_max;
    logic [COUNT_W-1:0]  active_samples;
    logic [ENERGY_W-1:0] window_energy;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pre_threshold;
    logic [SAMPLE_W-1:0] follow_threshold;
    logic [SAMPLE_W-1:0] rearm_threshold;
    logic [COUNT_W-1:0]  window_length;
    logic [COUNT_W-1:0]  min_active;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  active;
    logic [SAMPLE_W-1:0] max;
    logic [ENERGY_W-1:0] energy;
  } win_t;

  typedef struct packed {
    logic hit;
    logic completed;
    logic candidate;
  } flags_t;

endpackage

// File: hdl/dphd_core.sv
// Detector state machine and window accumulators for the drum pad hit detector.
// Updates state once per transferred sample and forms the block result.
// Depends on dphd_pkg.
module dphd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  dphd_pkg::in_item_t item_i,
  input  dphd_pkg::cfg_t     cfg_i,
  output dphd_pkg::out_item_t res_o
);
  import dphd_pkg::*;

  logic [1:0]          mode_q, mode_d, mode_mid;
  win_t                win_q, win_base, win_new;
  win_t                diag_q, diag_d, diag_base, diag_mid;
  logic                at_start_q;
  logic                began_q, began_d;
  logic [SAMPLE_W-1:0] peak_q, peak_base, peak_d;
  flags_t              flags_q, flags_base, flags_d;
  logic [SAMPLE_W-1:0] s;
  logic                open_win, run_win, complete, accept_hit, active;

  always_comb begin
    s = '0;
    s[SAMPLE_BITS-1:0] = item_i.sample[SAMPLE_BITS-1:0];
  end

  always_comb begin
    began_d    = at_start_q ? (mode_q == MODE_LOCKED) : began_q;
    peak_base  = at_start_q ? '0 : peak_q;
    flags_base = at_start_q ? '0 : flags_q;
    diag_base  = at_start_q ? '0 : diag_q;
    peak_d     = (s > peak_base) ? s : peak_base;

    open_win = (mode_q == MODE_IDLE) && (s >= cfg_i.pre_threshold);
    run_win  = open_win || (mode_q == MODE_VALIDATING);
    win_base = open_win ? '0 : win_q;
    active   = (s >= cfg_i.follow_threshold);

    win_new.count  = win_base.count + COUNT_W'(1);
    win_new.active = win_base.active + COUNT_W'(active);
    win_new.max    = (s > win_base.max) ? s : win_base.max;
    win_new.energy = win_base.energy + ENERGY_W'(s);

    complete   = run_win && (win_new.count >= cfg_i.window_length);
    accept_hit = win_new.active >= cfg_i.min_active;

    if (complete) begin
      mode_mid = accept_hit ? MODE_LOCKED : MODE_IDLE;
    end else if (open_win) begin
      mode_mid = MODE_VALIDATING;
    end else begin
      mode_mid = mode_q;
    end

    flags_d.candidate = flags_base.candidate | open_win;
    flags_d.completed = flags_base.completed | complete;
    flags_d.hit       = flags_base.hit | (complete & accept_hit);
    diag_mid          = complete ? win_new : diag_base;

    diag_d = diag_mid;
    mode_d = mode_mid;
    if (item_i.last_in_block) begin
      // unfinished window opened in this block reports its running values
      if ((mode_mid == MODE_VALIDATING) && flags_d.candidate && !flags_d.completed) begin
        diag_d = win_new;
      end
      if (began_d && (peak_d < cfg_i.rearm_threshold)) begin
        mode_d = MODE_IDLE;
      end
    end
  end

  always_comb begin
    res_o.raw_peak             = peak_d;
    res_o.candidate_started    = flags_d.candidate;
    res_o.validation_completed = flags_d.completed;
    res_o.hit_detected         = flags_d.hit;
    res_o.validation_max       = diag_d.max;
    res_o.active_samples       = diag_d.active;
    res_o.window_energy        = diag_d.energy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      win_q      <= '0;
      diag_q     <= '0;
      at_start_q <= 1'b1;
      began_q    <= 1'b0;
      peak_q     <= '0;
      flags_q    <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      if (run_win) begin
        win_q <= win_new;
      end
      diag_q     <= diag_d;
      at_start_q <= item_i.last_in_block;
      began_q    <= began_d;
      peak_q     <= peak_d;
      flags_q    <= flags_d;
    end
  end

endmodule

// File: hdl/drum_pad_hit_detector.sv
// Top level of the drum pad hit detector: configuration registers, detector
// core and a two-entry result buffer. Depends on dphd_pkg and dphd_core.
//
// Takes one pad sample per clock cycle, unless in_stall_o is high, with no
// gaps of its own; each sample marked last_in_block produces one registered
// result. The results pass through a two-entry output buffer, so samples keep
// flowing while one result waits; in_stall_o rises only when both entries are
// full, and it is a registered signal. Configuration writes are always ready
// and take effect on the next sample.
module drum_pad_hit_detector (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  dphd_pkg::in_item_t                     in_item_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output dphd_pkg::out_item_t                    out_item_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dphd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dphd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import dphd_pkg::*;

  cfg_t      cfg_q;
  out_item_t res;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_fire, out_fire, push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign push        = in_fire && in_item_i.last_in_block;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_threshold    <= SAMPLE_W'(200);
      cfg_q.follow_threshold <= SAMPLE_W'(100);
      cfg_q.rearm_threshold  <= SAMPLE_W'(150);
      cfg_q.window_length    <= COUNT_W'(8);
      cfg_q.min_active       <= COUNT_W'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PRE_THRESHOLD:    cfg_q.pre_threshold    <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_FOLLOW_THRESHOLD: cfg_q.follow_threshold <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_REARM_THRESHOLD:  cfg_q.rearm_threshold  <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_WINDOW_LENGTH:    cfg_q.window_length    <= cfg_wdata_i[COUNT_W-1:0];
        REG_MIN_ACTIVE:       cfg_q.min_active       <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  dphd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

// File: hdl/dphd_checker.sv
// Port-level checker for the drum pad hit detector, bound to the top level.
// Depends on dphd_pkg.
module dphd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input dphd_pkg::in_item_t              in_item_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input dphd_pkg::out_item_t             out_item_o
);
  import dphd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && in_item_i.last_in_block))
    else $error("result without a block-end transfer");

  a_hit_completed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.hit_detected |-> out_item_o.validation_completed)
    else $error("hit reported without a completed window");

endmodule

bind drum_pad_hit_detector dphd_checker u_dphd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: sim/drum_pad_hit_detector_tb.sv
// Testbench for drum_pad_hit_detector: drives pad samples in blocks, writes the
// configuration registers between phases and checks every block report against an
// in-bench detector model. Depends on dphd_pkg and the RTL only.
`timescale 1ns / 1ps

module drum_pad_hit_detector_tb;
  import dphd_pkg::*;

  class hit_report_tracker;
    cfg_t                regs;
    logic [1:0]          mode;
    win_t                win;
    win_t                diag;
    flags_t              flags;
    logic [SAMPLE_W-1:0] peak;
    bit                  at_start;
    bit                  began_locked;
    out_item_t           due_reports[$];
    int                  errors;

    function new();
      regs = '{pre_threshold: 16'd200, follow_threshold: 16'd100,
               rearm_threshold: 16'd150, window_length: 8'd8, min_active: 8'd4};
      mode = MODE_IDLE;
      win = '0;
      diag = '0;
      flags = '0;
      peak = '0;
      at_start = 1'b1;
      began_locked = 1'b0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PRE_THRESHOLD:    regs.pre_threshold = data;
        REG_FOLLOW_THRESHOLD: regs.follow_threshold = data;
        REG_REARM_THRESHOLD:  regs.rearm_threshold = data;
        REG_WINDOW_LENGTH:    regs.window_length = data[COUNT_W-1:0];
        REG_MIN_ACTIVE:       regs.min_active = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void gather(logic [SAMPLE_W-1:0] s);
      win.count = win.count + 1'b1;
      if (s >= regs.follow_threshold) win.active = win.active + 1'b1;
      if (s > win.max) win.max = s;
      win.energy = win.energy + ENERGY_W'(s);
    endfunction

    // Advance the detector by one transferred sample; queue a report at block end.
    function void note_sample(in_item_t it);
      logic [SAMPLE_W-1:0] s;
      bit                  in_window;
      out_item_t           rep;
      s = it.sample;
      in_window = 1'b0;
      if (at_start) begin
        began_locked = (mode == MODE_LOCKED);
        peak = '0;
        flags = '0;
        diag = '0;
        at_start = 1'b0;
      end
      if (s > peak) peak = s;
      if (mode == MODE_IDLE) begin
        if (s >= regs.pre_threshold) begin
          win = '0;
          mode = MODE_VALIDATING;
          gather(s);
          flags.candidate = 1'b1;
          in_window = 1'b1;
        end
      end else if (mode == MODE_VALIDATING) begin
        gather(s);
        in_window = 1'b1;
      end
      if (in_window && win.count >= regs.window_length) begin
        flags.completed = 1'b1;
        diag = win;
        if (win.active >= regs.min_active) begin
          mode = MODE_LOCKED;
          flags.hit = 1'b1;
        end else begin
          mode = MODE_IDLE;
        end
      end
      if (it.last_in_block) begin
        if (mode == MODE_VALIDATING && flags.candidate && !flags.completed) diag = win;
        if (began_locked && peak < regs.rearm_threshold) mode = MODE_IDLE;
        rep.raw_peak             = peak;
        rep.candidate_started    = flags.candidate;
        rep.validation_completed = flags.completed;
        rep.hit_detected         = flags.hit;
        rep.validation_max       = diag.max;
        rep.active_samples       = diag.active;
        rep.window_energy        = diag.energy;
        due_reports.push_back(rep);
        at_start = 1'b1;
      end
    endfunction

    task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v) report($sformatf("%s: got %0d, expected %0d", name, got_v, exp_v));
    endtask

    task check_report(out_item_t got);
      out_item_t exp;
      if (due_reports.size() == 0) begin
        report("block report with none expected");
      end else begin
        exp = due_reports.pop_front();
        check_field("raw_peak", got.raw_peak, exp.raw_peak);
        check_field("candidate_started", got.candidate_started, exp.candidate_started);
        check_field("validation_completed", got.validation_completed,
                    exp.validation_completed);
        check_field("hit_detected", got.hit_detected, exp.hit_detected);
        check_field("validation_max", got.validation_max, exp.validation_max);
        check_field("active_samples", got.active_samples, exp.active_samples);
        check_field("window_energy", got.window_energy, exp.window_energy);
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  hit_report_tracker tracker = new();
  cfg_t              cur;
  bit                tx_gaps = 1'b0;
  bit                rx_stalls = 1'b0;
  int                stall_left = 0;
  int                blk_left = 0;
  int                sent = 0;

  drum_pad_hit_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) tracker.note_sample(in_item_i);
      if (out_valid_o && !out_stall_i) tracker.check_report(out_item_o);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("drum_pad_hit_detector_tb NOT OK");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high.
  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic last);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{sample: s, last_in_block: last};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic push(logic [SAMPLE_W-1:0] s);
    if (blk_left == 0) begin
      case ($urandom_range(0, 9))
        0:       blk_left = 1;
        1:       blk_left = $urandom_range(20, 40);
        default: blk_left = $urandom_range(2, 8);
      endcase
    end
    blk_left--;
    send_sample(s, blk_left == 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_all(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx[0] = REG_PRE_THRESHOLD;
    idx[1] = REG_FOLLOW_THRESHOLD;
    idx[2] = REG_REARM_THRESHOLD;
    idx[3] = REG_WINDOW_LENGTH;
    idx[4] = REG_MIN_ACTIVE;
    val[0] = c.pre_threshold;
    val[1] = c.follow_threshold;
    val[2] = c.rearm_threshold;
    // upper bits of the 8-bit registers are don't-care
    val[3] = {8'($urandom), c.window_length};
    val[4] = {8'($urandom), c.min_active};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur = c;
  endtask

  function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] t);
    int v;
    v = int'(t) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] quiet_sample();
    logic [SAMPLE_W-1:0] lim;
    lim = (cur.pre_threshold < cur.rearm_threshold) ? cur.pre_threshold : cur.rearm_threshold;
    if (lim == 0) return '0;
    return SAMPLE_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic strike();
    int body;
    body = (cur.window_length > 40) ? 40 : int'(cur.window_length);
    push(SAMPLE_W'($urandom_range(cur.pre_threshold, 65535)));
    for (int i = 1; i < body; i++) begin
      if ($urandom_range(0, 9) < 7 || cur.follow_threshold == 0)
        push(SAMPLE_W'($urandom_range(cur.follow_threshold, 65535)));
      else
        push(SAMPLE_W'($urandom_range(0, cur.follow_threshold - 1)));
    end
    repeat ($urandom_range(0, 6)) push(quiet_sample());
  endtask

  task automatic run_phase(cfg_t c, int n_items, bit calm);
    int first;
    logic [SAMPLE_W-1:0] t;
    drain();
    write_all(c);
    tx_gaps = !calm && ($urandom_range(0, 3) != 0);
    rx_stalls = !calm && ($urandom_range(0, 3) != 0);
    first = sent;
    while (sent - first < n_items) begin
      case ($urandom_range(0, 9))
        0: push(16'($urandom));
        1: begin
          case ($urandom_range(0, 2))
            0:       t = cur.pre_threshold;
            1:       t = cur.follow_threshold;
            default: t = cur.rearm_threshold;
          endcase
          push(near(t));
        end
        2, 3: repeat ($urandom_range(1, 6)) push(quiet_sample());
        default: strike();
      endcase
    end
    while (blk_left != 0) push(quiet_sample());
  endtask

  initial begin
    logic [SAMPLE_W-1:0] d_s [20];
    bit                  d_l [20];
    cfg_t                c;
    // quiet block; window across two blocks ending in a hit; lockout held at
    // the rearm level, released below it; a window that fails; sub-threshold
    d_s = '{16'd0, 16'd200, 16'd99, 16'd100, 16'd65535, 16'd150, 16'd150, 16'd150,
            16'd150, 16'd150, 16'd149, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0,
            16'd0, 16'd0, 16'd99, 16'd199};
    d_l = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1};
    cur = tracker.regs;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 20; i++) send_sample(d_s[i], d_l[i]);

    run_phase(tracker.regs, 170, 1'b0);
    run_phase('{pre_threshold: 16'd0, follow_threshold: 16'd0, rearm_threshold: 16'd0,
                window_length: 8'd1, min_active: 8'd0}, 40, 1'b0);
    run_phase('{pre_threshold: 16'hFFFF, follow_threshold: 16'd0,
                rearm_threshold: 16'hFFFF, window_length: 8'd255, min_active: 8'd255},
              300, 1'b0);
    // zero-length window completes on its opening sample
    run_phase('{pre_threshold: 16'd1000, follow_threshold: 16'd500, rearm_threshold: 16'd300,
                window_length: 8'd0, min_active: 8'd0}, 60, 1'b0);
    // min_active beyond the window and thresholds above pre
    run_phase('{pre_threshold: 16'd300, follow_threshold: 16'hFFFF, rearm_threshold: 16'd4000,
                window_length: 8'd4, min_active: 8'd5}, 60, 1'b0);
    repeat (3) begin
      c.pre_threshold = SAMPLE_W'($urandom_range(0, 4000));
      c.follow_threshold = SAMPLE_W'($urandom_range(0, c.pre_threshold));
      c.rearm_threshold = SAMPLE_W'($urandom_range(0, c.pre_threshold));
      c.window_length = COUNT_W'($urandom_range(1, 16));
      c.min_active = COUNT_W'($urandom_range(0, c.window_length));
      run_phase(c, 60, 1'b0);
    end
    run_phase('{pre_threshold: 16'd200, follow_threshold: 16'd100, rearm_threshold: 16'd150,
                window_length: 8'd8, min_active: 8'd4}, 120, 1'b1);

    drain();
    repeat (10) @(negedge clk_i);
    if (tracker.due_reports.size() != 0)
      tracker.report($sformatf("%0d block reports never arrived", tracker.due_reports.size()));
    if (tracker.errors == 0) begin
      $display("drum_pad_hit_detector_tb OK");
    end else begin
      $display("drum_pad_hit_detector_tb NOT OK");
    end
    $finish;
  end

endmodule
